[hdl/dnd_pkg.sv]
// Package: shared types and constants for the DNS name decompressor.
package dnd_pkg;

   localparam int unsigned POS_W   = 14;   // width of a compression pointer target
   localparam int unsigned TLEN_W  = 8;    // dotted text never exceeds 255 characters
   localparam int unsigned WIDX_W  = 6;    // 64 words of four characters
   localparam logic [7:0]  PTR_MARK   = 8'd192;
   localparam logic [7:0]  DOT_CHAR   = 8'h2E;
   localparam logic [9:0]  NAME_CAP   = 10'd255;
   localparam logic [7:0]  HOPS_RESET = 8'd16;
   localparam logic        KIND_LOAD   = 1'b0;
   localparam logic        KIND_DECODE = 1'b1;
   localparam logic        REG_MAX_HOPS = 1'b0;  // register select bit for max_pointer_hops

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HOPS   = 2'd1,
      ERR_LENGTH = 2'd2,
      ERR_RANGE  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEN_ADDR,
      S_LEN,
      S_PTR,
      S_LBL,
      S_FLUSH,
      S_RD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] address;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] name_chunk;
      logic [2:0]  valid_count;
      logic        last;
      logic [8:0]  consumed_bytes;
      logic [1:0]  error_code;
   } rsp_item_type;

   // Control from the walk sequencer to the text buffer
   typedef struct packed {
      logic              append;
      logic              flush;
      logic [7:0]        byte_val;
      logic [1:0]        lane;
      logic [WIDX_W-1:0] word_idx;
      logic [WIDX_W-1:0] rd_idx;
   } tb_ctrl_type;

endpackage

[hdl/dnd_pkt_mem.sv]
// Packet byte memory: one write port, one registered read port.
module dnd_pkt_mem
   import dnd_pkg::*;
#(
   parameter int unsigned PACKET_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(PACKET_BYTES)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic [$clog2(PACKET_BYTES)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [PACKET_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dnd_text_buf.sv]
// Text buffer: packs decoded characters into words and holds them for output.
module dnd_text_buf
   import dnd_pkg::*;
(
   input  logic        clock,
   input  tb_ctrl_type ctrl,
   output logic [31:0] rd_word
);

   logic [31:0] words [2**WIDX_W];
   logic [31:0] pack_ff, pack_in;
   logic [31:0] rd_word_ff;
   logic        wr_en;
   logic [31:0] wr_word;

   // merge the new character into its lane; lane 0 starts a fresh word
   always_comb begin
      pack_in = pack_ff;
      wr_en   = 1'b0;
      wr_word = pack_ff;
      if (ctrl.append) begin
         if (ctrl.lane == 2'd0) begin
            pack_in = {24'd0, ctrl.byte_val};
         end else begin
            pack_in = pack_ff | ({24'd0, ctrl.byte_val} << {ctrl.lane, 3'b000});
         end
         if (ctrl.lane == 2'd3) begin
            wr_en   = 1'b1;
            wr_word = {ctrl.byte_val, pack_ff[23:0]};
         end
      end else if (ctrl.flush && ctrl.lane != 2'd0) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff <= pack_in;
      if (wr_en) begin
         words[ctrl.word_idx] <= wr_word;
      end
      rd_word_ff <= words[ctrl.rd_idx];
   end

   assign rd_word = rd_word_ff;

endmodule

[hdl/dnd_walk_ctrl.sv]
// Walk sequencer: follows labels and pointers, then formats the result items.
module dnd_walk_ctrl
   import dnd_pkg::*;
#(
   parameter int unsigned PACKET_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            decode_go,
   input  logic [11:0]                     start_addr,
   input  logic [7:0]                      max_hops,
   output logic                            busy,
   output logic [$clog2(PACKET_BYTES)-1:0] pkt_rd_addr,
   input  logic [7:0]                      pkt_rd_data,
   output tb_ctrl_type                     tb_ctrl,
   input  logic [31:0]                     tb_rd_word,
   output logic                            rsp_valid,
   output rsp_item_type                    rsp_item
);

   localparam int unsigned AW = $clog2(PACKET_BYTES);
   localparam logic [POS_W:0] PB_LIMIT = (POS_W+1)'(PACKET_BYTES);

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         hop_ff, hop_in;
   logic [7:0]         rem_ff, rem_in;
   logic [TLEN_W-1:0]  tl_ff, tl_in;
   logic [8:0]         cons_ff, cons_in;
   logic               jumped_ff, jumped_in;
   logic [WIDX_W-1:0]  chunk_ff, chunk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic [POS_W:0]     pos_plus1;
   logic [POS_W:0]     pos_plus_b;
   logic [9:0]         need;
   logic               is_ptr;
   logic               is_end;
   logic               pos_out;
   logic               ptr_out;
   logic               lbl_long;
   logic               lbl_out;
   logic               hops_spent;
   logic [8:0]         chunk_rem;
   logic               chunk_last;
   logic [2:0]         chunk_valid;
   logic [31:0]        chunk_mask;

   assign pos_plus1  = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign pos_plus_b = {1'b0, pos_ff} + {{(POS_W-7){1'b0}}, pkt_rd_data};
   assign need       = {2'b00, tl_ff} + {9'd0, (tl_ff != '0)} + {2'b00, pkt_rd_data};
   assign is_end     = pkt_rd_data == 8'd0;
   assign is_ptr     = pkt_rd_data >= PTR_MARK;
   assign pos_out    = {1'b0, pos_ff} >= PB_LIMIT;
   assign ptr_out    = pos_plus1 >= PB_LIMIT;
   assign hops_spent = hop_ff >= max_hops;
   assign lbl_long   = need > NAME_CAP;
   assign lbl_out    = pos_plus_b >= PB_LIMIT;

   assign chunk_rem   = {1'b0, tl_ff} - {1'b0, chunk_ff, 2'b00};
   assign chunk_last  = chunk_rem <= 9'd4;
   assign chunk_valid = chunk_last ? chunk_rem[2:0] : 3'd4;
   always_comb begin
      case (chunk_valid)
         3'd0:    chunk_mask = 32'h0000_0000;
         3'd1:    chunk_mask = 32'h0000_00FF;
         3'd2:    chunk_mask = 32'h0000_FFFF;
         3'd3:    chunk_mask = 32'h00FF_FFFF;
         default: chunk_mask = 32'hFFFF_FFFF;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (decode_go) state_in = S_LEN_ADDR;
         S_LEN_ADDR: state_in = pos_out ? S_IDLE : S_LEN;
         S_LEN: begin
            if (is_end) begin
               state_in = S_FLUSH;
            end else if (is_ptr) begin
               state_in = (ptr_out || hops_spent) ? S_IDLE : S_PTR;
            end else begin
               state_in = (lbl_long || lbl_out) ? S_IDLE : S_LBL;
            end
         end
         S_PTR:   state_in = S_LEN_ADDR;
         S_LBL:   if (rem_ff == 8'd1) state_in = S_LEN_ADDR;
         S_FLUSH: state_in = S_RD;
         S_RD:    state_in = S_OUT;
         S_OUT:   state_in = chunk_last ? S_IDLE : S_RD;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in       = pos_ff;
      hop_in       = hop_ff;
      rem_in       = rem_ff;
      tl_in        = tl_ff;
      cons_in      = cons_ff;
      jumped_in    = jumped_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pkt_rd_addr  = pos_plus1[AW-1:0];
      tb_ctrl          = '0;
      tb_ctrl.byte_val = pkt_rd_data;
      tb_ctrl.lane     = tl_ff[1:0];
      tb_ctrl.word_idx = tl_ff[TLEN_W-1:2];
      tb_ctrl.rd_idx   = chunk_ff;

      case (state_ff)
         S_IDLE: begin
            if (decode_go) begin
               pos_in    = {{(POS_W-12){1'b0}}, start_addr};
               hop_in    = 8'd0;
               rem_in    = 8'd0;
               tl_in     = '0;
               cons_in   = 9'd1;
               jumped_in = 1'b0;
               chunk_in  = '0;
            end
         end
         S_LEN_ADDR: begin
            pkt_rd_addr = pos_ff[AW-1:0];
            if (pos_out) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{32'd0, 3'd0, 1'b1, cons_ff, ERR_RANGE};
            end
         end
         S_LEN: begin
            if (is_ptr && !is_end) begin
               if (ptr_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{32'd0, 3'd0, 1'b1, cons_ff, ERR_RANGE};
               end else if (hops_spent) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{32'd0, 3'd0, 1'b1, cons_ff, ERR_HOPS};
               end else begin
                  // keep the high pointer bits; the low byte arrives next cycle
                  pos_in = {pkt_rd_data[5:0], 8'd0};
                  if (!jumped_ff) cons_in = cons_ff + 9'd1;
               end
            end else if (!is_end) begin
               if (lbl_long || lbl_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{32'd0, 3'd0, 1'b1,
                                   jumped_ff ? cons_ff : cons_ff + 9'd1,
                                   lbl_long ? ERR_LENGTH : ERR_RANGE};
               end else begin
                  pos_in = pos_plus1[POS_W-1:0];
                  rem_in = pkt_rd_data;
                  if (!jumped_ff) cons_in = cons_ff + 9'd1 + {1'b0, pkt_rd_data};
                  // separator before every label but the first
                  if (tl_ff != '0) begin
                     tb_ctrl.append   = 1'b1;
                     tb_ctrl.byte_val = DOT_CHAR;
                     tl_in            = tl_ff + TLEN_W'(1);
                  end
               end
            end
         end
         S_PTR: begin
            pos_in    = {pos_ff[POS_W-1:8], pkt_rd_data};
            hop_in    = hop_ff + 8'd1;
            jumped_in = 1'b1;
         end
         S_LBL: begin
            tb_ctrl.append = 1'b1;
            tl_in          = tl_ff + TLEN_W'(1);
            rem_in         = rem_ff - 8'd1;
            pos_in         = pos_plus1[POS_W-1:0];
         end
         S_FLUSH: begin
            tb_ctrl.flush = 1'b1;
         end
         S_RD: begin
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{tb_rd_word & chunk_mask, chunk_valid, chunk_last,
                             chunk_last ? cons_ff : 9'd0, ERR_NONE};
            chunk_in     = chunk_ff + WIDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         hop_ff       <= 8'd0;
         rem_ff       <= 8'd0;
         tl_ff        <= '0;
         cons_ff      <= 9'd1;
         jumped_ff    <= 1'b0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         hop_ff       <= hop_in;
         rem_ff       <= rem_in;
         tl_ff        <= tl_in;
         cons_ff      <= cons_in;
         jumped_ff    <= jumped_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hdl/dns_name_decompressor.sv]
// Top level: DNS name decompressor with packet memory, walker and register port.
//
// Usage. Items enter on req_item, accepted when start is high and busy is low.
// A load item (kind 0) writes data_byte to packet memory at address;
// writes at or beyond PACKET_BYTES are dropped. Loads never raise busy.
// A decode item (kind 1) walks the name from address, following compression
// pointers, and raises busy until its last result has been formed.
// Results leave on rsp_item, each shown for exactly one cycle with rsp_valid
// high; the receiver cannot hold them off, so none are ever stalled.
// Decode steps, one packet memory read port being the limit: each label's
//   length byte and characters, each pointer's two bytes, the terminating
//   zero, a flush of the text buffer, then a read per four-character result.
// The last result is registered and shows in the first cycle with busy low.
// An error (hop limit, 255-character cap, address beyond memory) stops the
// walk and yields a single result with the error code.
// max_pointer_hops sits at byte address 0 of the csr_ port; write it only
// while the block is idle. Reset (synchronous, active high) returns the
// sequencer to idle and max_pointer_hops to 16; packet memory is not cleared.
module dns_name_decompressor
   import dnd_pkg::*;
#(
   parameter int unsigned PACKET_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int unsigned AW = $clog2(PACKET_BYTES);
   localparam logic [POS_W:0] PB_LIMIT = (POS_W+1)'(PACKET_BYTES);

   logic [7:0]    max_hops_ff, max_hops_in;
   logic          csr_wr;
   logic          accept;
   logic          load_wr;
   logic          decode_go;
   logic [AW-1:0] pkt_rd_addr;
   logic [7:0]    pkt_rd_data;
   tb_ctrl_type   tb_ctrl;
   logic [31:0]   tb_rd_word;

   // register port: single register, always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign max_hops_in = (csr_wr && csr_paddr[2] == REG_MAX_HOPS) ? csr_pwdata[7:0]
                                                                  : max_hops_ff;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_HOPS) ? {24'd0, max_hops_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hops_ff <= HOPS_RESET;
      end else begin
         max_hops_ff <= max_hops_in;
      end
   end

   // split accepted items into loads and decodes
   assign accept    = start && !busy;
   assign decode_go = accept && req_item.kind == KIND_DECODE;
   assign load_wr   = accept && req_item.kind == KIND_LOAD &&
                      {{(POS_W-11){1'b0}}, req_item.address} < PB_LIMIT;

   dnd_pkt_mem #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_pkt_mem (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (AW'({{(POS_W-12){1'b0}}, req_item.address})),
      .wr_data (req_item.data_byte),
      .rd_addr (pkt_rd_addr),
      .rd_data (pkt_rd_data)
   );

   dnd_text_buf u_text_buf (
      .clock   (clock),
      .ctrl    (tb_ctrl),
      .rd_word (tb_rd_word)
   );

   dnd_walk_ctrl #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_walk_ctrl (
      .clock       (clock),
      .reset       (reset),
      .decode_go   (decode_go),
      .start_addr  (req_item.address),
      .max_hops    (max_hops_ff),
      .busy        (busy),
      .pkt_rd_addr (pkt_rd_addr),
      .pkt_rd_data (pkt_rd_data),
      .tb_ctrl     (tb_ctrl),
      .tb_rd_word  (tb_rd_word),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

`ifndef SYNTHESIS
   // a decode always occupies the walker in the following cycle
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == KIND_DECODE) |=> busy)
      else $error("decode item accepted but walker idle");

   // an error result is always a lone, empty, final item
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.error_code != ERR_NONE) |->
      (rsp_item.last && rsp_item.valid_count == 3'd0 && rsp_item.name_chunk == 32'd0))
      else $error("error result not empty and final");

   // more results follow a non-final one, so the walker is still busy
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |-> busy)
      else $error("non-final result with walker idle");

   // only a final result carries a consumed count
   a_cons_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |->
      (rsp_item.consumed_bytes == 9'd0 && rsp_item.valid_count == 3'd4))
      else $error("non-final result malformed");
`endif

endmodule

[test/dnd_checker.sv]
// Checker: mirrors packet memory, predicts decoded names and compares every result.
module dnd_checker
   import dnd_pkg::*;
#(
   parameter int unsigned PACKET_BYTES = 4096,
   parameter logic [2:0]  HOPS_ADDR    = 3'd0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           mismatches,
   output int           pending,
   output int           results_seen,
   output int           loads_seen,
   output int           decodes_seen,
   output int           hop_errors,
   output int           cap_errors,
   output int           range_errors
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]   packet_mirror [0:PACKET_BYTES-1];
   logic [7:0]   hop_limit = HOPS_RESET;
   rsp_item_type expected_chunks [$];

   initial begin
      mismatches   = 0;
      pending      = 0;
      results_seen = 0;
      loads_seen   = 0;
      decodes_seen = 0;
      hop_errors   = 0;
      cap_errors   = 0;
      range_errors = 0;
   end

   // walk the name from origin and queue the chunks it must produce
   task automatic walk_name(input logic [11:0] origin);
      int unsigned  pos;
      int unsigned  hops;
      int unsigned  tlen;
      int unsigned  used;
      int unsigned  need;
      int unsigned  nres;
      int unsigned  valid;
      logic [7:0]   b;
      logic [7:0]   text [0:255];
      bit           jumped;
      bit           done;
      err_type      fault;
      rsp_item_type r;
      pos    = origin;
      hops   = 0;
      tlen   = 0;
      used   = 1;
      jumped = 1'b0;
      done   = 1'b0;
      fault  = ERR_NONE;
      while (!done) begin
         if (pos >= PACKET_BYTES) begin
            fault = ERR_RANGE;
            done  = 1'b1;
         end else begin
            b = packet_mirror[pos];
            if (b == 8'd0) begin
               done = 1'b1;
            end else if (b >= PTR_MARK) begin
               if (pos + 1 >= PACKET_BYTES) begin
                  fault = ERR_RANGE;
                  done  = 1'b1;
               end else if (hops >= hop_limit) begin
                  fault = ERR_HOPS;
                  done  = 1'b1;
               end else begin
                  if (!jumped) used++;
                  pos    = {18'd0, b[5:0], packet_mirror[pos + 1]};
                  hops++;
                  jumped = 1'b1;
               end
            end else begin
               if (!jumped) used++;
               need = tlen + ((tlen != 0) ? 1 : 0) + b;
               if (need > NAME_CAP) begin
                  fault = ERR_LENGTH;
                  done  = 1'b1;
               end else if (pos + b >= PACKET_BYTES) begin
                  fault = ERR_RANGE;
                  done  = 1'b1;
               end else begin
                  if (tlen != 0) begin
                     text[tlen] = DOT_CHAR;
                     tlen++;
                  end
                  for (int unsigned i = 1; i <= b; i++) begin
                     text[tlen] = packet_mirror[pos + i];
                     tlen++;
                  end
                  pos = pos + b + 1;
                  if (!jumped) used += b;
               end
            end
         end
      end

      if (fault != ERR_NONE) begin
         r                = '0;
         r.last           = 1'b1;
         r.consumed_bytes = used[8:0];
         r.error_code     = fault;
         expected_chunks.push_back(r);
         case (fault)
            ERR_HOPS:   hop_errors++;
            ERR_LENGTH: cap_errors++;
            default:    range_errors++;
         endcase
      end else begin
         nres = (tlen + 3) / 4;
         if (nres == 0) nres = 1;
         for (int unsigned k = 0; k < nres; k++) begin
            r     = '0;
            valid = 0;
            for (int unsigned i = 0; i < 4; i++) begin
               if (k * 4 + i < tlen) begin
                  r.name_chunk[8*i +: 8] = text[k * 4 + i];
                  valid++;
               end
            end
            r.valid_count    = valid[2:0];
            r.last           = (k + 1 == nres);
            r.consumed_bytes = (k + 1 == nres) ? used[8:0] : 9'd0;
            r.error_code     = ERR_NONE;
            expected_chunks.push_back(r);
         end
      end
   endtask

   task automatic check_chunk(input rsp_item_type got);
      rsp_item_type want;
      results_seen++;
      if (expected_chunks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result chunk %h count %0d last %0b consumed %0d error %0d",
                     $realtime, got.name_chunk, got.valid_count, got.last,
                     got.consumed_bytes, got.error_code);
      end else begin
         want = expected_chunks.pop_front();
         if (got.name_chunk !== want.name_chunk || got.valid_count !== want.valid_count ||
             got.last !== want.last || got.consumed_bytes !== want.consumed_bytes ||
             got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result mismatch, expected chunk %h count %0d last %0b consumed %0d error %0d",
                        $realtime, want.name_chunk, want.valid_count, want.last,
                        want.consumed_bytes, want.error_code);
               $display("%0t:                   got      chunk %h count %0d last %0b consumed %0d error %0d",
                        $realtime, got.name_chunk, got.valid_count, got.last,
                        got.consumed_bytes, got.error_code);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hop_limit = HOPS_RESET;
      end else begin
         if (rsp_valid) check_chunk(rsp_item);
         if (start && !busy) begin
            if (req_item.kind == KIND_LOAD) begin
               loads_seen++;
               if (req_item.address < PACKET_BYTES)
                  packet_mirror[req_item.address] = req_item.data_byte;
            end else begin
               decodes_seen++;
               walk_name(req_item.address);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == HOPS_ADDR) hop_limit = csr_pwdata[7:0];
            end else if (csr_paddr == HOPS_ADDR && csr_prdata !== {24'd0, hop_limit}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: hop limit read back %h, expected %h",
                           $realtime, csr_prdata, {24'd0, hop_limit});
            end
         end
      end
      pending = expected_chunks.size();
   end

endmodule

[test/tb.sv]
// Testbench top: drives loads, decodes and register writes and read-backs into the name decompressor.
module tb;
   import dnd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PKT_BYTES      = 4096;
   localparam logic [2:0]  HOPS_ADDR      = {REG_MAX_HOPS, 2'b00};
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          SETTLE_CYCLES  = 8;
   // names are laid out upwards from address 1; beyond this the area is reused
   localparam int          HEAP_TOP       = 3400;
   // noise writes land here and are never decoded
   localparam int          SCRATCH_LO     = 3800;
   localparam int          SCRATCH_HI     = 4079;
   // the top sixteen bytes are kept for the running-off-the-end cases
   localparam int          EDGE_LO        = 4080;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int mismatches;
   int pending;
   int results_seen;
   int loads_seen;
   int decodes_seen;
   int hop_errors;
   int cap_errors;
   int range_errors;

   // stimulus bookkeeping
   int          n_items = 0;
   int          gap_pct = 0;
   int          heap    = 1;
   logic [11:0] good_names [$];   // offsets of complete, fully written names
   logic [7:0]  mid_limit;
   int          quiet   = 0;

   dns_name_decompressor #(
      .PACKET_BYTES(PKT_BYTES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dnd_checker #(
      .PACKET_BYTES(PKT_BYTES),
      .HOPS_ADDR   (HOPS_ADDR)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen),
      .loads_seen   (loads_seen),
      .decodes_seen (decodes_seen),
      .hop_errors   (hop_errors),
      .cap_errors   (cap_errors),
      .range_errors (range_errors)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog: count cycles in which no item, result or register access moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_psel) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Offer one item: idle at random first, then hold start until busy is low
   // at a rising edge. Start is left high so back-to-back items need no toggle.
   task automatic offer(input req_item_type it);
      logic [31:0] noise;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         noise = $urandom;
         start    <= 1'b0;
         req_item <= noise[$bits(req_item_type)-1:0];
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_items++;
   endtask

   task automatic put_byte(input logic [11:0] addr, input logic [7:0] value);
      req_item_type it;
      it.kind      = KIND_LOAD;
      it.address   = addr;
      it.data_byte = value;
      offer(it);
   endtask

   task automatic ask_name(input logic [11:0] addr);
      req_item_type it;
      logic [31:0]  filler;
      filler       = $urandom;
      it.kind      = KIND_DECODE;
      it.address   = addr;
      it.data_byte = filler[7:0];   // ignored by a decode, toggle it anyway
      offer(it);
   endtask

   // Append a length byte and its label text at the heap.
   task automatic put_label(input int len);
      put_byte(12'(heap), 8'(len));
      heap++;
      for (int j = 0; j < len; j++) begin
         put_byte(12'(heap), 8'($urandom_range(0, 255)));
         heap++;
      end
   endtask

   task automatic put_pointer(input logic [13:0] target);
      put_byte(12'(heap), PTR_MARK | {2'b00, target[13:8]});
      put_byte(12'(heap + 1), target[7:0]);
      heap += 2;
   endtask

   // Reuse the name area once it fills: forget every name but the root at zero.
   task automatic make_room();
      if (heap > HEAP_TOP) begin
         heap = 1;
         good_names.delete();
         good_names.push_back(12'd0);
      end
   endtask

   // Mostly short labels, now and then up to the 63 limit or into 64..120.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 8);
      if (r < 96) return $urandom_range(9, 63);
      return $urandom_range(64, 120);
   endfunction

   // Lay down a well-formed name: labels, then a zero or a pointer to a known name.
   task automatic build_name(input int labels, input bit chain, output logic [11:0] origin);
      logic [11:0] target;
      make_room();
      origin = 12'(heap);
      for (int i = 0; i < labels; i++) put_label(pick_len());
      if (chain && good_names.size() > 0) begin
         target = good_names[$urandom_range(0, good_names.size() - 1)];
         put_pointer({2'b00, target});
      end else begin
         put_byte(12'(heap), 8'd0);
         heap++;
      end
      good_names.push_back(origin);
   endtask

   // Faulty names: a pointer loop, a pointer beyond memory, and three ways of
   // running off the top of memory.
   task automatic broken_name(input int variant, input int where);
      logic [11:0] origin;
      int          len;
      case (variant)
         0: begin
            make_room();
            origin = 12'(heap);
            put_pointer({2'b00, origin});
            ask_name(origin);
         end
         1: begin
            make_room();
            origin = 12'(heap);
            put_pointer(14'($urandom_range(PKT_BYTES, 16383)));
            ask_name(origin);
         end
         2: begin
            put_byte(12'(PKT_BYTES - 1), PTR_MARK | 8'($urandom_range(0, 63)));
            ask_name(12'(PKT_BYTES - 1));
         end
         3: begin
            // length byte alone is read; its label would pass the top
            put_byte(12'(where), 8'($urandom_range(PKT_BYTES - where, 191)));
            ask_name(12'(where));
         end
         default: begin
            // label fits exactly, the next length byte lies beyond memory
            len = PKT_BYTES - 1 - where;
            put_byte(12'(where), 8'(len));
            for (int j = 1; j <= len; j++)
               put_byte(12'(where + j), 8'($urandom_range(0, 255)));
            ask_name(12'(where));
         end
      endcase
   endtask

   // Hold off until every expected result is in and the block has settled.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the hop limit, then read it back; the checker compares the read.
   task automatic set_hop_limit(input logic [7:0] limit);
      logic [31:0] upper;
      upper = $urandom;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HOPS_ADDR;
      csr_pwdata  <= {upper[31:8], limit};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic directed_checks();
      logic [11:0] origin;
      int          tail;
      // root name at address zero
      put_byte(12'd0, 8'd0);
      ask_name(12'd0);
      good_names.push_back(12'd0);
      // plain labels, a pointer as the very first byte, labels then a pointer
      build_name(3, 1'b0, origin);
      ask_name(origin);
      build_name(0, 1'b1, origin);
      ask_name(origin);
      build_name(2, 1'b1, origin);
      ask_name(origin);
      // longest legal name: four labels of 63 give 255 characters, 64 results
      origin = 12'(heap);
      for (int j = 0; j < 4; j++) put_label(63);
      tail = heap;
      put_byte(12'(tail), 8'd0);
      heap++;
      ask_name(origin);
      // one more label on top of that breaks the text cap
      put_byte(12'(tail), 8'($urandom_range(1, 191)));
      ask_name(origin);
      // a length in the 64..191 band is still a label
      origin = 12'(heap);
      put_label(70);
      put_byte(12'(heap), 8'd0);
      heap++;
      ask_name(origin);
      good_names.push_back(origin);
      // pointer loop, pointer beyond memory, the top-of-memory cases
      broken_name(0, 0);
      broken_name(1, 0);
      broken_name(2, 0);
      broken_name(3, PKT_BYTES - 2);
      broken_name(4, EDGE_LO);
   endtask

   task automatic random_step();
      logic [11:0] origin;
      int          r;
      int          n;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         build_name($urandom_range(0, 3), $urandom_range(0, 1), origin);
         ask_name(origin);
      end else if (r < 75) begin
         ask_name(good_names[$urandom_range(0, good_names.size() - 1)]);
      end else if (r < 83) begin
         broken_name($urandom_range(0, 4), $urandom_range(EDGE_LO, PKT_BYTES - 2));
      end else if (r < 91) begin
         n = $urandom_range(1, 3);
         for (int j = 0; j < n; j++)
            put_byte(12'($urandom_range(SCRATCH_LO, SCRATCH_HI)), 8'($urandom_range(0, 255)));
      end else if (r < 94) begin
         drain_results();
      end else begin
         ask_name(12'd0);
      end
   endtask

   task automatic run_phase(input logic [7:0] limit, input int gap, input int count);
      int stop_at;
      drain_results();
      set_hop_limit(limit);
      gap_pct = gap;
      stop_at = n_items + count;
      while (n_items < stop_at) random_step();
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mid_limit   = 8'($urandom_range(2, 15));
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases run at the reset hop limit with no idling
      directed_checks();
      // then random names at a spread of hop limits and sender gaps
      run_phase(8'd1, 0, 70);
      run_phase(8'd255, 76, 70);
      run_phase(mid_limit, 37, 70);
      run_phase(8'd0, 0, 40);
      run_phase(HOPS_RESET, 76, 50);
      drain_results();

      $display("Run covered %0d items: %0d loads and %0d decodes giving %0d results",
               n_items, loads_seen, decodes_seen, results_seen);
      $display("Faults hit: %0d hop limit, %0d text cap, %0d beyond memory; hop limits 16 1 255 %0d 0",
               hop_errors, cap_errors, range_errors, mid_limit);
      if (mismatches == 0 && pending == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
